// ===== design/gcaf_pkg.sv =====
// Shared constants, control types and filter coefficient tables for the
// gyro complementary angle filter. No dependencies; every other file uses it.
package gcaf_pkg;

    localparam int SAMPLE_W   = 32;             // Q3.28 sample width
    localparam int HIST_W     = 40;             // filter output history, Q7.32
    localparam int ACC_W      = 64;             // multiply-accumulate width
    localparam int HALF_W     = SAMPLE_W - 1;   // half_period, unsigned Q0.31
    localparam int LIMIT_W    = SAMPLE_W - 1;   // rate_limit, unsigned
    localparam int CNT_W      = 16;             // sample counter / warm-up width
    localparam int MUL_A_W    = 32;             // coefficient / half_period operand
    localparam int MUL_B_W    = HIST_W;         // sample / history operand
    localparam int STEP_W     = 5;
    localparam int NUM_FRAC   = 28;
    localparam int DEN_FRAC   = 20;
    localparam int OUT_GUARD  = 4;
    localparam int HALF_FRAC  = 31;
    localparam int FF_SHIFT   = NUM_FRAC - DEN_FRAC - OUT_GUARD;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 32;
    localparam int IN_TDATA_W = 2 * SAMPLE_W;
    localparam int OUT_TDATA_W = 2 * SAMPLE_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BIAS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP        = 3'd5;

    localparam logic [HALF_W-1:0]  RST_HALF_PERIOD = 31'd5368709;
    localparam logic [LIMIT_W-1:0] RST_RATE_LIMIT  = 31'd671088640;
    localparam logic [CNT_W-1:0]   RST_WARMUP      = 16'd500;

    // multiplier operand selects
    localparam logic [1:0] A_HALF = 2'd0;
    localparam logic [1:0] A_LPFF = 2'd1;
    localparam logic [1:0] A_HPFF = 2'd2;
    localparam logic [1:0] A_FB   = 2'd3;

    localparam logic [2:0] B_ABS   = 3'd0;
    localparam logic [2:0] B_LPIN  = 3'd1;
    localparam logic [2:0] B_LPOUT = 3'd2;
    localparam logic [2:0] B_DSUM  = 3'd3;
    localparam logic [2:0] B_REL   = 3'd4;
    localparam logic [2:0] B_HPIN  = 3'd5;
    localparam logic [2:0] B_HPOUT = 3'd6;

    // accumulator operations
    localparam logic [2:0] ACC_NONE      = 3'd0;
    localparam logic [2:0] ACC_INIT      = 3'd1;  // acc = feed-forward rounding constant
    localparam logic [2:0] ACC_ADD       = 3'd2;
    localparam logic [2:0] ACC_SHIFT_ADD = 3'd3;  // acc = (acc >>> FF_SHIFT) + prod
    localparam logic [2:0] ACC_LOAD      = 3'd4;  // acc = rounding constant + prod

    typedef struct packed {
        logic [1:0] a_sel;
        logic [2:0] b_sel;
        logic [2:0] coef_idx;
        logic [1:0] hist_idx;
        logic [2:0] acc_op;
        logic       d_en;
        logic       dsum_en;
        logic       istep_en;
        logic       integ_en;
        logic       rel_en;
        logic       lp_done;
        logic       hp_done;
        logic       fsum_en;
        logic       out_en;
    } t_ctrl;

    // high-pass feed-forward, Q.28
    function automatic logic signed [MUL_A_W-1:0] hp_ff_coef(input logic [2:0] idx);
        logic signed [MUL_A_W-1:0] c;
        case (idx)
            3'd0:    c = 32'sd218573570;
            3'd1:    c = -32'sd874294280;
            3'd2:    c = 32'sd1311441420;
            3'd3:    c = -32'sd874294280;
            3'd4:    c = 32'sd218573570;
            default: c = '0;
        endcase
        return c;
    endfunction

    // low-pass feed-forward, Q.28
    function automatic logic signed [MUL_A_W-1:0] lp_ff_coef(input logic [2:0] idx);
        logic signed [MUL_A_W-1:0] c;
        case (idx)
            3'd0:    c = 32'sd8386;
            3'd1:    c = 32'sd33544;
            3'd2:    c = 32'sd50313;
            3'd3:    c = 32'sd33544;
            3'd4:    c = 32'sd8386;
            default: c = '0;
        endcase
        return c;
    endfunction

    // shared feedback, Q.20, applied as y += fb[k] * y[n-1-k]
    function automatic logic signed [MUL_A_W-1:0] fb_coef(input logic [1:0] idx);
        logic signed [MUL_A_W-1:0] c;
        case (idx)
            2'd0:    c = 32'sd3764073;
            2'd1:    c = -32'sd5086957;
            2'd2:    c = 32'sd3066141;
            default: c = -32'sd695216;
        endcase
        return c;
    endfunction

endpackage

// ===== design/gcaf_mac.sv =====
// Shared multiply-accumulate unit: registered 32x40 signed product and a
// 64-bit accumulator with in-place rounding shift. Depends on gcaf_pkg.
module gcaf_mac (
    input  logic                                 i_clk,
    input  logic signed [gcaf_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [gcaf_pkg::MUL_B_W-1:0]  i_b,
    input  logic [2:0]                           i_acc_op,
    output logic signed [gcaf_pkg::ACC_W-1:0]    o_prod,
    output logic signed [gcaf_pkg::ACC_W-1:0]    o_acc
);
    import gcaf_pkg::*;

    localparam int FULL_W = MUL_A_W + MUL_B_W;
    localparam logic signed [ACC_W-1:0] FF_RND = ACC_W'(1) << (FF_SHIFT - 1);

    logic signed [FULL_W-1:0] w_full;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    assign w_full = i_a * i_b;

    always_comb begin
        case (i_acc_op)
            ACC_INIT:      n_acc = FF_RND;
            ACC_ADD:       n_acc = r_acc + r_prod;
            ACC_SHIFT_ADD: n_acc = (r_acc >>> FF_SHIFT) + r_prod;
            ACC_LOAD:      n_acc = FF_RND + r_prod;
            default:       n_acc = r_acc;
        endcase
    end

    // sums wrap modulo 2^64 by design
    always_ff @(posedge i_clk) begin
        r_prod <= w_full[ACC_W-1:0];
        r_acc  <= n_acc;
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ===== design/gcaf_seq.sv =====
// Step sequencer: counts through the 23 steps of one sample and decodes the
// operand selects, accumulator ops and datapath strobes. Depends on gcaf_pkg.
module gcaf_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_out_hold,
    output logic             o_ready,
    output gcaf_pkg::t_ctrl  o_ctrl
);
    import gcaf_pkg::*;

    localparam logic [STEP_W-1:0] S_LP_FF0  = 5'd0;
    localparam logic [STEP_W-1:0] S_LP_FF1  = 5'd1;
    localparam logic [STEP_W-1:0] S_INT_MUL = 5'd2;
    localparam logic [STEP_W-1:0] S_LP_FF2  = 5'd3;
    localparam logic [STEP_W-1:0] S_LP_FF3  = 5'd4;
    localparam logic [STEP_W-1:0] S_LP_FF4  = 5'd5;
    localparam logic [STEP_W-1:0] S_LP_FB0  = 5'd6;
    localparam logic [STEP_W-1:0] S_LP_FB1  = 5'd7;
    localparam logic [STEP_W-1:0] S_LP_FB2  = 5'd8;
    localparam logic [STEP_W-1:0] S_LP_FB3  = 5'd9;
    localparam logic [STEP_W-1:0] S_HP_FF0  = 5'd10;
    localparam logic [STEP_W-1:0] S_HP_FF1  = 5'd11;
    localparam logic [STEP_W-1:0] S_HP_FF2  = 5'd12;
    localparam logic [STEP_W-1:0] S_HP_FF3  = 5'd13;
    localparam logic [STEP_W-1:0] S_HP_FF4  = 5'd14;
    localparam logic [STEP_W-1:0] S_HP_FB0  = 5'd15;
    localparam logic [STEP_W-1:0] S_HP_FB1  = 5'd16;
    localparam logic [STEP_W-1:0] S_HP_FB2  = 5'd17;
    localparam logic [STEP_W-1:0] S_HP_FB3  = 5'd18;
    localparam logic [STEP_W-1:0] S_HP_ACC  = 5'd19;
    localparam logic [STEP_W-1:0] S_HP_DONE = 5'd20;
    localparam logic [STEP_W-1:0] S_FSUM    = 5'd21;
    localparam logic [STEP_W-1:0] S_OUT     = 5'd22;

    logic              r_live;
    logic              r_busy;
    logic              n_busy;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              w_last;
    t_ctrl             c;

    assign w_last = r_busy && (r_step == S_OUT) && !i_out_hold;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = S_LP_FF0;
        end else if (w_last) begin
            n_busy = 1'b0;
            n_step = S_LP_FF0;
        end else if (r_busy && r_step != S_OUT) begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_busy <= 1'b0;
            r_step <= S_LP_FF0;
        end else begin
            r_live <= 1'b1;
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    // multiply issued in step s is accumulated in step s+1
    always_comb begin
        c          = '0;
        c.a_sel    = A_LPFF;
        c.b_sel    = B_ABS;
        c.acc_op   = ACC_NONE;
        if (r_busy) begin
            case (r_step)
                S_LP_FF0: begin
                    c.acc_op = ACC_INIT;
                    c.d_en   = 1'b1;
                end
                S_LP_FF1: begin
                    c.coef_idx = 3'd1;  c.b_sel = B_LPIN;  c.hist_idx = 2'd0;
                    c.acc_op   = ACC_ADD;
                    c.dsum_en  = 1'b1;
                end
                S_INT_MUL: begin
                    c.a_sel  = A_HALF;  c.b_sel = B_DSUM;
                    c.acc_op = ACC_ADD;
                end
                S_LP_FF2: begin
                    // product in flight is the trapezoid step, not a filter term
                    c.coef_idx = 3'd2;  c.b_sel = B_LPIN;  c.hist_idx = 2'd1;
                    c.istep_en = 1'b1;
                end
                S_LP_FF3: begin
                    c.coef_idx = 3'd3;  c.b_sel = B_LPIN;  c.hist_idx = 2'd2;
                    c.acc_op   = ACC_ADD;
                    c.integ_en = 1'b1;
                end
                S_LP_FF4: begin
                    c.coef_idx = 3'd4;  c.b_sel = B_LPIN;  c.hist_idx = 2'd3;
                    c.acc_op   = ACC_ADD;
                    c.rel_en   = 1'b1;
                end
                S_LP_FB0: begin
                    c.a_sel  = A_FB;  c.coef_idx = 3'd0;
                    c.b_sel  = B_LPOUT;  c.hist_idx = 2'd0;
                    c.acc_op = ACC_ADD;
                end
                S_LP_FB1: begin
                    c.a_sel  = A_FB;  c.coef_idx = 3'd1;
                    c.b_sel  = B_LPOUT;  c.hist_idx = 2'd1;
                    c.acc_op = ACC_SHIFT_ADD;
                end
                S_LP_FB2: begin
                    c.a_sel  = A_FB;  c.coef_idx = 3'd2;
                    c.b_sel  = B_LPOUT;  c.hist_idx = 2'd2;
                    c.acc_op = ACC_ADD;
                end
                S_LP_FB3: begin
                    c.a_sel  = A_FB;  c.coef_idx = 3'd3;
                    c.b_sel  = B_LPOUT;  c.hist_idx = 2'd3;
                    c.acc_op = ACC_ADD;
                end
                S_HP_FF0: begin
                    c.a_sel  = A_HPFF;  c.coef_idx = 3'd0;  c.b_sel = B_REL;
                    c.acc_op = ACC_ADD;
                end
                S_HP_FF1: begin
                    // low-pass result leaves the accumulator here
                    c.a_sel  = A_HPFF;  c.coef_idx = 3'd1;
                    c.b_sel  = B_HPIN;  c.hist_idx = 2'd0;
                    c.acc_op = ACC_LOAD;
                    c.lp_done = 1'b1;
                end
                S_HP_FF2: begin
                    c.a_sel  = A_HPFF;  c.coef_idx = 3'd2;
                    c.b_sel  = B_HPIN;  c.hist_idx = 2'd1;
                    c.acc_op = ACC_ADD;
                end
                S_HP_FF3: begin
                    c.a_sel  = A_HPFF;  c.coef_idx = 3'd3;
                    c.b_sel  = B_HPIN;  c.hist_idx = 2'd2;
                    c.acc_op = ACC_ADD;
                end
                S_HP_FF4: begin
                    c.a_sel  = A_HPFF;  c.coef_idx = 3'd4;
                    c.b_sel  = B_HPIN;  c.hist_idx = 2'd3;
                    c.acc_op = ACC_ADD;
                end
                S_HP_FB0: begin
                    c.a_sel  = A_FB;  c.coef_idx = 3'd0;
                    c.b_sel  = B_HPOUT;  c.hist_idx = 2'd0;
                    c.acc_op = ACC_ADD;
                end
                S_HP_FB1: begin
                    c.a_sel  = A_FB;  c.coef_idx = 3'd1;
                    c.b_sel  = B_HPOUT;  c.hist_idx = 2'd1;
                    c.acc_op = ACC_SHIFT_ADD;
                end
                S_HP_FB2: begin
                    c.a_sel  = A_FB;  c.coef_idx = 3'd2;
                    c.b_sel  = B_HPOUT;  c.hist_idx = 2'd2;
                    c.acc_op = ACC_ADD;
                end
                S_HP_FB3: begin
                    c.a_sel  = A_FB;  c.coef_idx = 3'd3;
                    c.b_sel  = B_HPOUT;  c.hist_idx = 2'd3;
                    c.acc_op = ACC_ADD;
                end
                S_HP_ACC: begin
                    c.acc_op = ACC_ADD;
                end
                S_HP_DONE: begin
                    c.hp_done = 1'b1;
                end
                S_FSUM: begin
                    c.fsum_en = 1'b1;
                end
                S_OUT: begin
                    c.out_en = !i_out_hold;
                end
                default: begin
                    c.acc_op = ACC_NONE;
                end
            endcase
        end
    end

    assign o_ready = r_live && !r_busy;
    assign o_ctrl  = c;

endmodule

// ===== design/gyro_complementary_angle_filter_core.sv =====
// One sample at a time: no input beat is accepted while a sample is in
// progress. The single shared 32x40 multiplier runs 19 products per sample
// (trapezoid step plus two 9-term IIR filters).
// Ready drops the cycle after accept and returns once the result is loaded
// into the output register, which holds it until the sink takes it.
// Reset: synchronous active low; restores register defaults, clears history.
module gyro_complementary_angle_filter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [gcaf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gcaf_pkg::CFG_W-1:0]          i_cfg_data,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [gcaf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // rate_sample, abs_angle
    // output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [gcaf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,  // fused_angle, relative_angle
    output logic                                o_m_axis_tuser   // rate_clamped
);
    import gcaf_pkg::*;

    // saturate 39-bit signed to 32
    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [38:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v[38:31] == 8'h00 || v[38:31] == 8'hFF) begin
            r = v[31:0];
        end else begin
            r = v[38] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

    // saturate 44-bit signed to 40
    function automatic logic signed [HIST_W-1:0] sat40(input logic signed [43:0] v);
        logic signed [HIST_W-1:0] r;
        if (v[43:39] == 5'h00 || v[43:39] == 5'h1F) begin
            r = v[39:0];
        end else begin
            r = v[43] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
        end
        return r;
    endfunction

    localparam logic signed [ACC_W-1:0] HALF_RND = ACC_W'(1) << (HALF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] DEN_RND  = ACC_W'(1) << (DEN_FRAC - 1);
    localparam logic signed [41:0]      OUT_RND  = 42'(1) << (OUT_GUARD - 1);

    // configuration
    logic signed [SAMPLE_W-1:0] r_gyro_bias;
    logic signed [SAMPLE_W-1:0] r_angle_bias;
    logic [HALF_W-1:0]          r_half_period;
    logic [LIMIT_W-1:0]         r_rate_limit;
    logic signed [SAMPLE_W-1:0] r_output_offset;
    logic [CNT_W-1:0]           r_warmup;

    // state
    logic [CNT_W-1:0]           r_count;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] r_integral;
    logic signed [SAMPLE_W-1:0] r_lp_in  [4];
    logic signed [HIST_W-1:0]   r_lp_out [4];
    logic signed [SAMPLE_W-1:0] r_hp_in  [4];
    logic signed [HIST_W-1:0]   r_hp_out [4];

    // per-sample working registers
    logic signed [SAMPLE_W-1:0] r_rate;
    logic signed [SAMPLE_W-1:0] r_abs;
    logic                       r_clamped;
    logic signed [SAMPLE_W-1:0] r_dnow;
    logic signed [SAMPLE_W-1:0] r_dold;
    logic signed [SAMPLE_W:0]   r_dsum;
    logic signed [SAMPLE_W:0]   r_istep;
    logic signed [SAMPLE_W-1:0] r_rel;
    logic signed [HIST_W-1:0]   r_y_lp;
    logic signed [HIST_W-1:0]   r_y_hp;
    logic signed [41:0]         r_fsum;

    // output register
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_fused;
    logic signed [SAMPLE_W-1:0] r_out_rel;
    logic                       r_out_clamp;

    logic                       w_ready;
    logic                       w_accept;
    logic                       w_out_hold;
    t_ctrl                      c;

    logic signed [SAMPLE_W-1:0] w_in_rate;
    logic signed [SAMPLE_W-1:0] w_in_abs;
    logic signed [SAMPLE_W-1:0] w_lim;
    logic signed [SAMPLE_W-1:0] w_neg_lim;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [ACC_W-1:0]    w_prod;
    logic signed [ACC_W-1:0]    w_acc;
    logic signed [ACC_W-1:0]    w_prod_rnd;
    logic signed [ACC_W-1:0]    w_acc_rnd;
    logic signed [HIST_W-1:0]   w_y;
    logic signed [SAMPLE_W:0]   w_dnow_full;
    logic signed [SAMPLE_W:0]   w_dold_full;
    logic signed [SAMPLE_W+1:0] w_integ_sum;
    logic signed [SAMPLE_W:0]   w_rel_full;
    logic signed [38:0]         w_fused_full;

    assign w_accept   = i_s_axis_tvalid && w_ready;
    assign w_out_hold = r_out_vld && !i_m_axis_tready;

    gcaf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_out_hold (w_out_hold),
        .o_ready    (w_ready),
        .o_ctrl     (c)
    );

    // operand select for the shared multiplier
    always_comb begin
        case (c.a_sel)
            A_HALF:  w_mul_a = signed'({1'b0, r_half_period});
            A_LPFF:  w_mul_a = lp_ff_coef(c.coef_idx);
            A_HPFF:  w_mul_a = hp_ff_coef(c.coef_idx);
            default: w_mul_a = fb_coef(c.coef_idx[1:0]);
        endcase
        case (c.b_sel)
            B_ABS:   w_mul_b = MUL_B_W'(r_abs);
            B_LPIN:  w_mul_b = MUL_B_W'(r_lp_in[c.hist_idx]);
            B_LPOUT: w_mul_b = r_lp_out[c.hist_idx];
            B_DSUM:  w_mul_b = MUL_B_W'(r_dsum);
            B_REL:   w_mul_b = MUL_B_W'(r_rel);
            B_HPIN:  w_mul_b = MUL_B_W'(r_hp_in[c.hist_idx]);
            B_HPOUT: w_mul_b = r_hp_out[c.hist_idx];
            default: w_mul_b = '0;
        endcase
    end

    gcaf_mac u_mac (
        .i_clk    (i_clk),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .i_acc_op (c.acc_op),
        .o_prod   (w_prod),
        .o_acc    (w_acc)
    );

    // input clamp
    assign w_in_rate = i_s_axis_tdata[SAMPLE_W-1:0];
    assign w_in_abs  = i_s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign w_lim     = signed'({1'b0, r_rate_limit});
    assign w_neg_lim = -w_lim;

    // integrator and fused-output arithmetic
    assign w_dnow_full  = (SAMPLE_W+1)'(r_rate) - (SAMPLE_W+1)'(r_gyro_bias);
    assign w_dold_full  = (SAMPLE_W+1)'(r_prev) - (SAMPLE_W+1)'(r_gyro_bias);
    assign w_prod_rnd   = w_prod + HALF_RND;
    assign w_integ_sum  = (SAMPLE_W+2)'(r_integral) + (SAMPLE_W+2)'(r_istep);
    assign w_rel_full   = (SAMPLE_W+1)'(r_integral) - (SAMPLE_W+1)'(r_angle_bias);
    assign w_acc_rnd    = w_acc + DEN_RND;
    assign w_y          = sat40(w_acc_rnd[ACC_W-1:DEN_FRAC]);
    assign w_fused_full = 39'(signed'(r_fsum[41:OUT_GUARD])) + 39'(r_output_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_bias     <= '0;
            r_angle_bias    <= '0;
            r_half_period   <= RST_HALF_PERIOD;
            r_rate_limit    <= RST_RATE_LIMIT;
            r_output_offset <= '0;
            r_warmup        <= RST_WARMUP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GYRO_BIAS:     r_gyro_bias     <= i_cfg_data[SAMPLE_W-1:0];
                REG_ANGLE_BIAS:    r_angle_bias    <= i_cfg_data[SAMPLE_W-1:0];
                REG_HALF_PERIOD:   r_half_period   <= i_cfg_data[HALF_W-1:0];
                REG_RATE_LIMIT:    r_rate_limit    <= i_cfg_data[LIMIT_W-1:0];
                REG_OUTPUT_OFFSET: r_output_offset <= i_cfg_data[SAMPLE_W-1:0];
                REG_WARMUP:        r_warmup        <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // filter and integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_prev     <= '0;
            r_integral <= '0;
            for (int k = 0; k < 4; k++) begin
                r_lp_in[k]  <= '0;
                r_lp_out[k] <= '0;
                r_hp_in[k]  <= '0;
                r_hp_out[k] <= '0;
            end
        end else begin
            if (c.dsum_en) begin
                r_prev <= r_rate;
            end
            if (c.integ_en) begin
                // held at zero through warm-up
                if (r_count > r_warmup) begin
                    r_integral <= sat32(39'(w_integ_sum));
                end else begin
                    r_integral <= '0;
                end
                if (r_count != {CNT_W{1'b1}}) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (c.lp_done) begin
                for (int k = 3; k > 0; k--) begin
                    r_lp_in[k]  <= r_lp_in[k-1];
                    r_lp_out[k] <= r_lp_out[k-1];
                end
                r_lp_in[0]  <= r_abs;
                r_lp_out[0] <= w_y;
            end
            if (c.hp_done) begin
                for (int k = 3; k > 0; k--) begin
                    r_hp_in[k]  <= r_hp_in[k-1];
                    r_hp_out[k] <= r_hp_out[k-1];
                end
                r_hp_in[0]  <= r_rel;
                r_hp_out[0] <= w_y;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_abs <= w_in_abs;
            if (w_in_rate > w_lim) begin
                r_rate    <= w_lim;
                r_clamped <= 1'b1;
            end else if (w_in_rate < w_neg_lim) begin
                r_rate    <= w_neg_lim;
                r_clamped <= 1'b1;
            end else begin
                r_rate    <= w_in_rate;
                r_clamped <= 1'b0;
            end
        end
        if (c.d_en) begin
            r_dnow <= sat32(39'(w_dnow_full));
            r_dold <= sat32(39'(w_dold_full));
        end
        if (c.dsum_en) begin
            r_dsum <= (SAMPLE_W+1)'(r_dnow) + (SAMPLE_W+1)'(r_dold);
        end
        if (c.istep_en) begin
            r_istep <= w_prod_rnd[ACC_W-1:HALF_FRAC];
        end
        if (c.rel_en) begin
            r_rel <= sat32(39'(w_rel_full));
        end
        if (c.lp_done) begin
            r_y_lp <= w_y;
        end
        if (c.hp_done) begin
            r_y_hp <= w_y;
        end
        if (c.fsum_en) begin
            r_fsum <= 42'(r_y_hp) + 42'(r_y_lp) + OUT_RND;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (c.out_en) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c.out_en) begin
            r_out_fused <= sat32(w_fused_full);
            r_out_rel   <= r_rel;
            r_out_clamp <= r_clamped;
        end
    end

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_rel, r_out_fused};
    assign o_m_axis_tuser  = r_out_clamp;

endmodule

// ===== design/gcaf_checker.sv =====
// Port-level checks for the filter core: handshake hold, sequencing and reset.
// Attached to gyro_complementary_angle_filter_core by the bind at the end.
module gcaf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [gcaf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input logic                                o_m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // one sample at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready the cycle after an accepted beat");

    // a new result only appears at the end of a sample in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared without a sample in progress");

    // reset leaves both sides quiet
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("handshake active after reset");

endmodule

bind gyro_complementary_angle_filter_core gcaf_checker u_gcaf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
